FILE: hdl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = IDX_W + 1;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_e;

  // Adds an offset below DEPTH to a slot index and wraps around the ring.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: hdl/dq_ram.sv
`timescale 1ns / 1ps

module dq_ram #(
  parameter int Depth = 16,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: hdl/double_ended_queue.sv
`timescale 1ns / 1ps
// The result word appears in the cycle after the request is taken, for one cycle.
// A new request is not taken while busy_o is high; busy_o is high during the result cycle,
// which is when the ring memory returns the word that becomes the new end.
// Front and rear words are kept in registers, so only a pop touches the memory read port.
// Reset (rst_ni low, asynchronous) empties the queue; the memory contents are not cleared.
// The result strobe cannot be stalled by the receiver.

module double_ended_queue
  import dq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [2:0]               operation_i,
  input  logic signed [WORD_W-1:0] value_i,
  output logic                     done_o,
  output logic signed [WORD_W-1:0] front_value_o,
  output logic signed [WORD_W-1:0] rear_value_o,
  output logic                     is_empty_o,
  output logic                     is_full_o,
  output logic [CNT_W-1:0]         occupancy_o,
  output logic [1:0]               error_code_o
);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [WORD_W-1:0]  front_q, front_d;
  logic [WORD_W-1:0]  rear_q, rear_d;
  err_e               err_q, err_d;
  logic               ld_front_q, ld_front_d;
  logic               ld_rear_q, ld_rear_d;

  logic               accept;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [WORD_W-1:0]  mem_rdata;
  logic [CNT_W-1:0]   count_m2;
  logic [WORD_W-1:0]  front_now, rear_now;

  assign accept   = start_i && (state_q == S_IDLE);
  assign count_m2 = count_q - CNT_W'(2);

  dq_ram #(
    .Depth (DEPTH),
    .Width (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (value_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // During the result cycle an end that moved inward takes the word just read.
  assign front_now = ld_front_q ? mem_rdata : front_q;
  assign rear_now  = ld_rear_q ? mem_rdata : rear_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    front_d    = front_q;
    rear_d     = rear_q;
    err_d      = err_q;
    ld_front_d = ld_front_q;
    ld_rear_d  = ld_rear_q;
    mem_we     = 1'b0;
    mem_waddr  = head_q;
    mem_re     = 1'b0;
    mem_raddr  = head_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d    = S_RESP;
          err_d      = ERR_OK;
          ld_front_d = 1'b0;
          ld_rear_d  = 1'b0;
          case (operation_i)
            OP_PUSH_FRONT: begin
              if (count_q == CNT_W'(DEPTH)) begin
                err_d = ERR_FULL;
              end else begin
                head_d    = ring_add(head_q, IDX_W'(DEPTH - 1));
                mem_we    = 1'b1;
                mem_waddr = head_d;
                count_d   = count_q + CNT_W'(1);
                front_d   = value_i;
                if (count_q == '0) begin
                  rear_d = value_i;
                end
              end
            end
            OP_PUSH_REAR: begin
              if (count_q == CNT_W'(DEPTH)) begin
                err_d = ERR_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ring_add(head_q, count_q[IDX_W-1:0]);
                count_d   = count_q + CNT_W'(1);
                rear_d    = value_i;
                if (count_q == '0) begin
                  front_d = value_i;
                end
              end
            end
            OP_POP_FRONT: begin
              if (count_q == '0) begin
                err_d = ERR_EMPTY;
              end else begin
                head_d  = ring_add(head_q, IDX_W'(1));
                count_d = count_q - CNT_W'(1);
                if (count_q > CNT_W'(1)) begin
                  mem_re     = 1'b1;
                  mem_raddr  = head_d;
                  ld_front_d = 1'b1;
                end
              end
            end
            OP_POP_REAR: begin
              if (count_q == '0) begin
                err_d = ERR_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
                if (count_q > CNT_W'(1)) begin
                  mem_re    = 1'b1;
                  mem_raddr = ring_add(head_q, count_m2[IDX_W-1:0]);
                  ld_rear_d = 1'b1;
                end
              end
            end
            default: begin
              // Peek and unused codes leave the queue as it is.
            end
          endcase
        end
      end
      S_RESP: begin
        state_d    = S_IDLE;
        front_d    = front_now;
        rear_d     = rear_now;
        ld_front_d = 1'b0;
        ld_rear_d  = 1'b0;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      err_q      <= ERR_OK;
      ld_front_q <= 1'b0;
      ld_rear_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      err_q      <= err_d;
      ld_front_q <= ld_front_d;
      ld_rear_q  <= ld_rear_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    rear_q  <= rear_d;
  end

  assign busy_o        = (state_q == S_RESP);
  assign done_o        = (state_q == S_RESP);
  assign front_value_o = (count_q == '0) ? '0 : front_now;
  assign rear_value_o  = (count_q == '0) ? '0 : rear_now;
  assign is_empty_o    = (count_q == '0);
  assign is_full_o     = (count_q == CNT_W'(DEPTH));
  assign occupancy_o   = count_q;
  assign error_code_o  = err_q;

  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o))
    else $error("result strobe without a preceding request");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("word count beyond depth");

  a_refused_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_code_o != ERR_OK) |-> (count_q == $past(count_q) &&
                                            head_q == $past(head_q)))
    else $error("refused request changed the queue");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |-> (front_value_o == '0 && rear_value_o == '0))
    else $error("empty queue reports nonzero end words");

  a_load_only_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld_front_q || ld_rear_q) |-> (done_o && count_q != '0 && !(ld_front_q && ld_rear_q)))
    else $error("memory word taken into an end register outside a valid pop");

endmodule

FILE: test/double_ended_queue_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import dq_pkg::*;

  // Operation codes outside the defined set; the block treats them as a peek.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

  localparam int RANDOM_WORDS = 850;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic signed [WORD_W-1:0] front;
    logic signed [WORD_W-1:0] rear;
    logic                     empty;
    logic                     full;
    logic [CNT_W-1:0]         occ;
    err_e                     err;
  } deque_view_t;

  typedef struct {
    logic [2:0]               op;
    logic signed [WORD_W-1:0] val;
    bit                       typed;
    deque_view_t              view;
  } plan_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic [2:0]               operation_i = OP_PEEK;
  logic signed [WORD_W-1:0] value_i = '0;
  logic                     busy_o;
  logic                     done_o;
  logic signed [WORD_W-1:0] front_value_o;
  logic signed [WORD_W-1:0] rear_value_o;
  logic                     is_empty_o;
  logic                     is_full_o;
  logic [CNT_W-1:0]         occupancy_o;
  logic [1:0]               error_code_o;

  // Shadow copy of the ring store, kept by the predictor.
  logic signed [WORD_W-1:0] ring_mem [DEPTH];
  int                       head_slot = 0;
  int                       word_cnt = 0;

  deque_view_t pending_views[$];
  plan_row_t   directed_plan[$];
  int          mismatches = 0;
  int          cycle_count = 0;

  double_ended_queue DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .front_value_o(front_value_o),
    .rear_value_o (rear_value_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o),
    .occupancy_o  (occupancy_o),
    .error_code_o (error_code_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Applies one request to the shadow deque and returns what the block should show.
  function automatic deque_view_t apply_request(input logic [2:0] op,
                                                input logic signed [WORD_W-1:0] val);
    deque_view_t v;
    v.err = ERR_OK;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
      if (word_cnt >= DEPTH) begin
        v.err = ERR_FULL;
      end else if (op == OP_PUSH_FRONT) begin
        head_slot = (head_slot + DEPTH - 1) % DEPTH;
        ring_mem[IDX_W'(head_slot)] = val;
        word_cnt++;
      end else begin
        ring_mem[IDX_W'((head_slot + word_cnt) % DEPTH)] = val;
        word_cnt++;
      end
    end else if (op == OP_POP_FRONT || op == OP_POP_REAR) begin
      if (word_cnt == 0) begin
        v.err = ERR_EMPTY;
      end else begin
        if (op == OP_POP_FRONT) begin
          head_slot = (head_slot + 1) % DEPTH;
        end
        word_cnt--;
      end
    end
    v.front = '0;
    v.rear  = '0;
    if (word_cnt != 0) begin
      v.front = ring_mem[IDX_W'(head_slot)];
      v.rear  = ring_mem[IDX_W'((head_slot + word_cnt - 1) % DEPTH)];
    end
    v.empty = (word_cnt == 0);
    v.full  = (word_cnt >= DEPTH);
    v.occ   = CNT_W'(word_cnt);
    return v;
  endfunction

  task automatic plan_row(input logic [2:0] op, input logic signed [WORD_W-1:0] val);
    plan_row_t r;
    r.op    = op;
    r.val   = val;
    r.typed = 1'b0;
    r.view  = '{default: '0, err: ERR_OK};
    directed_plan.push_back(r);
  endtask

  task automatic plan_known(input logic [2:0] op, input logic signed [WORD_W-1:0] val,
                            input logic signed [WORD_W-1:0] front,
                            input logic signed [WORD_W-1:0] rear,
                            input logic empty, input logic full,
                            input int occ, input err_e err);
    plan_row_t r;
    r.op         = op;
    r.val        = val;
    r.typed      = 1'b1;
    r.view.front = front;
    r.view.rear  = rear;
    r.view.empty = empty;
    r.view.full  = full;
    r.view.occ   = CNT_W'(occ);
    r.view.err   = err;
    directed_plan.push_back(r);
  endtask

  // Presents one word after an idle gap and waits until the block takes it.
  task automatic send_request(input logic [2:0] op, input logic signed [WORD_W-1:0] val,
                              input int gap, input bit typed,
                              input deque_view_t typed_view);
    deque_view_t predicted;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    do @(posedge clk_i); while (busy_o);
    predicted = apply_request(op, val);
    pending_views.push_back(typed ? typed_view : predicted);
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] expv,
                             input logic [WORD_W-1:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0h, got %0h", name, expv, actv);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    deque_view_t e;
    if (rst_ni && done_o) begin
      if (pending_views.size() == 0) begin
        $error("result word with no request outstanding");
        mismatches++;
      end else begin
        e = pending_views.pop_front();
        check_field("front_value", e.front, front_value_o);
        check_field("rear_value", e.rear, rear_value_o);
        check_field("is_empty", 32'(e.empty), 32'(is_empty_o));
        check_field("is_full", 32'(e.full), 32'(is_full_o));
        check_field("occupancy", 32'(e.occ), 32'(occupancy_o));
        check_field("error_code", 32'(e.err), 32'(error_code_o));
      end
    end
  end

  function automatic int draw_gap(input bit eager);
    return eager ? 0 : $urandom_range(0, 19);
  endfunction

  initial begin
    plan_row_t   r;
    deque_view_t none;
    logic [2:0]  op;
    logic signed [WORD_W-1:0] val;
    int          sent;
    int          burst_len;
    int          push_pct;
    bit          eager;

    none = '{default: '0, err: ERR_OK};

    // Requests on an empty queue, then one word and two words across the extremes.
    plan_known(OP_POP_FRONT, WORD_MAX, '0, '0, 1'b1, 1'b0, 0, ERR_EMPTY);
    plan_known(OP_POP_REAR, WORD_MIN, '0, '0, 1'b1, 1'b0, 0, ERR_EMPTY);
    plan_known(OP_PEEK, '0, '0, '0, 1'b1, 1'b0, 0, ERR_OK);
    plan_known(OP_SPARE_LO, -1, '0, '0, 1'b1, 1'b0, 0, ERR_OK);
    plan_known(OP_SPARE_HI, WORD_MAX, '0, '0, 1'b1, 1'b0, 0, ERR_OK);
    plan_known(OP_PUSH_FRONT, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0, 1'b0, 1, ERR_OK);
    plan_known(OP_PUSH_REAR, WORD_MIN, WORD_MAX, WORD_MIN, 1'b0, 1'b0, 2, ERR_OK);
    plan_known(OP_POP_FRONT, '0, WORD_MIN, WORD_MIN, 1'b0, 1'b0, 1, ERR_OK);
    plan_known(OP_POP_REAR, '0, '0, '0, 1'b1, 1'b0, 0, ERR_OK);
    // Fill to DEPTH from both ends so the head wraps, then push into a full queue.
    for (int i = 0; i < DEPTH; i++) begin
      plan_row((i % 2) ? OP_PUSH_FRONT : OP_PUSH_REAR,
               (i % 4 == 0) ? WORD_MIN : (i % 4 == 1) ? WORD_MAX :
               (i % 4 == 2) ? -1 : i);
    end
    plan_row(OP_PUSH_FRONT, 32'sh1234_5678);
    plan_row(OP_PUSH_REAR, -32'sh1234_5678);
    plan_row(OP_POP_FRONT, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      r = directed_plan[i];
      send_request(r.op, r.val, draw_gap($urandom_range(0, 1)), r.typed, r.view);
    end

    // Bursts with a random push/pop balance walk the queue between empty and full.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst_len = $urandom_range(10, 60);
      push_pct  = $urandom_range(5, 95);
      eager     = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst_len && sent < RANDOM_WORDS; k++) begin
        if ($urandom_range(0, 99) < 8) begin
          op = 3'($urandom_range(4, 7));
        end else if ($urandom_range(0, 99) < push_pct) begin
          op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        end else begin
          op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
        end
        case ($urandom_range(0, 11))
          0:       val = WORD_MAX;
          1:       val = WORD_MIN;
          2:       val = '0;
          3:       val = -1;
          default: val = $urandom;
        endcase
        send_request(op, val, draw_gap(eager), 1'b0, none);
        sent++;
      end
    end

    start_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
